### rtl/blit_rop_chroma_clip_pixel_core_defines.svh
// assertion macros shared by the blit raster-op core
// no dependencies; included by the modules that check their own logic
`ifndef BLIT_ROP_CHROMA_CLIP_PIXEL_CORE_DEFINES_SVH
`define BLIT_ROP_CHROMA_CLIP_PIXEL_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BRC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRC_ASSERT_IMPL(label, ante, cons)
`define BRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/brc_pkg.sv
// types, constants and register codes of the blit raster-op core
// no dependencies; used by every module of the core
package brc_pkg;

    localparam int PixBits          = 16;
    localparam int CoordInBits      = 11;
    localparam int EdgeBits         = 12;
    localparam int CoordBitsDefault = 11;
    localparam int ApbAddrBits      = 5;
    localparam int ApbDataBits      = 32;
    localparam int ModeBits         = 3;
    localparam int RangeBits        = 24;

    localparam logic [PixBits-1:0] RopTableReset = 16'hCCCC;

    typedef enum logic [2:0] {
        REG_MODE_FLAGS   = 3'd0,
        REG_CLIP_X_RANGE = 3'd1,
        REG_CLIP_Y_RANGE = 3'd2,
        REG_SRC_KEY_LOW  = 3'd3,
        REG_SRC_KEY_HIGH = 3'd4,
        REG_DST_KEY_LOW  = 3'd5,
        REG_DST_KEY_HIGH = 3'd6,
        REG_ROP_TABLE    = 3'd7
    } t_reg_idx;

    typedef enum logic [3:0] {
        ROP_ZERO   = 4'h0,
        ROP_NOR    = 4'h1,
        ROP_NS_AND = 4'h2,
        ROP_NOT_S  = 4'h3,
        ROP_S_ANDN = 4'h4,
        ROP_NOT_D  = 4'h5,
        ROP_XOR    = 4'h6,
        ROP_NAND   = 4'h7,
        ROP_AND    = 4'h8,
        ROP_XNOR   = 4'h9,
        ROP_DST    = 4'hA,
        ROP_NS_OR  = 4'hB,
        ROP_SRC    = 4'hC,
        ROP_S_ORN  = 4'hD,
        ROP_OR     = 4'hE,
        ROP_ONES   = 4'hF
    } t_rop;

    typedef struct packed {
        logic [PixBits-1:0]     src_pixel;
        logic [PixBits-1:0]     dst_pixel;
        logic [CoordInBits-1:0] pixel_x;
        logic [CoordInBits-1:0] pixel_y;
    } t_req;

    typedef struct packed {
        logic               write_enable;
        logic [PixBits-1:0] new_pixel;
    } t_res;

    typedef struct packed {
        logic [ModeBits-1:0]  mode_flags;
        logic [RangeBits-1:0] clip_x_range;
        logic [RangeBits-1:0] clip_y_range;
        logic [PixBits-1:0]   src_key_low;
        logic [PixBits-1:0]   src_key_high;
        logic [PixBits-1:0]   dst_key_low;
        logic [PixBits-1:0]   dst_key_high;
        logic [PixBits-1:0]   rop_table;
    } t_cfg;

    typedef struct packed {
        logic               clip;
        t_rop               code;
        logic [PixBits-1:0] src;
        logic [PixBits-1:0] dst;
    } t_mix;

endpackage

### rtl/brc_regs.sv
// apb configuration registers of the blit raster-op core
// depends on brc_pkg
module brc_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brc_pkg::ApbAddrBits-1:0]  paddr,
    input  logic [brc_pkg::ApbDataBits-1:0]  pwdata,
    output logic [brc_pkg::ApbDataBits-1:0]  prdata,
    output logic                             pready,
    output brc_pkg::t_cfg                    o_cfg
);

    brc_pkg::t_cfg     r_cfg;
    brc_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = brc_pkg::t_reg_idx'(paddr[brc_pkg::ApbAddrBits-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                mode_flags:   '0,
                clip_x_range: '0,
                clip_y_range: '0,
                src_key_low:  '0,
                src_key_high: '0,
                dst_key_low:  '0,
                dst_key_high: '0,
                rop_table:    brc_pkg::RopTableReset
            };
        end else if (w_wr) begin
            unique case (w_idx)
                brc_pkg::REG_MODE_FLAGS:
                    r_cfg.mode_flags   <= pwdata[brc_pkg::ModeBits-1:0];
                brc_pkg::REG_CLIP_X_RANGE:
                    r_cfg.clip_x_range <= pwdata[brc_pkg::RangeBits-1:0];
                brc_pkg::REG_CLIP_Y_RANGE:
                    r_cfg.clip_y_range <= pwdata[brc_pkg::RangeBits-1:0];
                brc_pkg::REG_SRC_KEY_LOW:
                    r_cfg.src_key_low  <= pwdata[brc_pkg::PixBits-1:0];
                brc_pkg::REG_SRC_KEY_HIGH:
                    r_cfg.src_key_high <= pwdata[brc_pkg::PixBits-1:0];
                brc_pkg::REG_DST_KEY_LOW:
                    r_cfg.dst_key_low  <= pwdata[brc_pkg::PixBits-1:0];
                brc_pkg::REG_DST_KEY_HIGH:
                    r_cfg.dst_key_high <= pwdata[brc_pkg::PixBits-1:0];
                brc_pkg::REG_ROP_TABLE:
                    r_cfg.rop_table    <= pwdata[brc_pkg::PixBits-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            brc_pkg::REG_MODE_FLAGS:
                prdata = brc_pkg::ApbDataBits'(r_cfg.mode_flags);
            brc_pkg::REG_CLIP_X_RANGE:
                prdata = brc_pkg::ApbDataBits'(r_cfg.clip_x_range);
            brc_pkg::REG_CLIP_Y_RANGE:
                prdata = brc_pkg::ApbDataBits'(r_cfg.clip_y_range);
            brc_pkg::REG_SRC_KEY_LOW:
                prdata = brc_pkg::ApbDataBits'(r_cfg.src_key_low);
            brc_pkg::REG_SRC_KEY_HIGH:
                prdata = brc_pkg::ApbDataBits'(r_cfg.src_key_high);
            brc_pkg::REG_DST_KEY_LOW:
                prdata = brc_pkg::ApbDataBits'(r_cfg.dst_key_low);
            brc_pkg::REG_DST_KEY_HIGH:
                prdata = brc_pkg::ApbDataBits'(r_cfg.dst_key_high);
            brc_pkg::REG_ROP_TABLE:
                prdata = brc_pkg::ApbDataBits'(r_cfg.rop_table);
        endcase
    end

endmodule

### rtl/brc_test.sv
// stages one and two: clip window and chroma range compares, then rop code select
// depends on brc_pkg and the assertion macro header
`include "blit_rop_chroma_clip_pixel_core_defines.svh"
module brc_test #(
    parameter int COORD_BITS = brc_pkg::CoordBitsDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  brc_pkg::t_req i_req,
    input  brc_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output brc_pkg::t_mix o_mix
);

    localparam logic [brc_pkg::EdgeBits-1:0] CoordMask =
        brc_pkg::EdgeBits'((1 << COORD_BITS) - 1);

    typedef struct packed {
        logic                        x_ok;
        logic                        y_ok;
        logic                        src_match;
        logic                        dst_match;
        logic [brc_pkg::PixBits-1:0] src;
        logic [brc_pkg::PixBits-1:0] dst;
    } t_s1;

    function automatic logic key_match(
        input logic [brc_pkg::PixBits-1:0] px,
        input logic [brc_pkg::PixBits-1:0] lo,
        input logic [brc_pkg::PixBits-1:0] hi
    );
        logic r_ok;
        logic g_ok;
        logic b_ok;
        r_ok = (px[15:11] >= lo[15:11]) && (px[15:11] <= hi[15:11]);
        g_ok = (px[10:5] >= lo[10:5]) && (px[10:5] <= hi[10:5]);
        b_ok = (px[4:0] >= lo[4:0]) && (px[4:0] <= hi[4:0]);
        return r_ok && g_ok && b_ok;
    endfunction

    logic                         r_s1_valid;
    t_s1                          r_s1;
    t_s1                          n_s1;
    logic                         r_s2_valid;
    brc_pkg::t_mix                r_s2;
    brc_pkg::t_mix                n_s2;
    logic [brc_pkg::EdgeBits-1:0] w_x;
    logic [brc_pkg::EdgeBits-1:0] w_y;
    logic [1:0]                   w_idx;

    assign w_x = {1'b0, i_req.pixel_x} & CoordMask;
    assign w_y = {1'b0, i_req.pixel_y} & CoordMask;

    always_comb begin
        n_s1.x_ok = (w_x >= i_cfg.clip_x_range[11:0]) && (w_x < i_cfg.clip_x_range[23:12]);
        n_s1.y_ok = (w_y >= i_cfg.clip_y_range[11:0]) && (w_y < i_cfg.clip_y_range[23:12]);
        n_s1.src_match = key_match(i_req.src_pixel, i_cfg.src_key_low, i_cfg.src_key_high);
        n_s1.dst_match = key_match(i_req.dst_pixel, i_cfg.dst_key_low, i_cfg.dst_key_high);
        n_s1.src = i_req.src_pixel;
        n_s1.dst = i_req.dst_pixel;
    end

    // bit1 from source key, bit0 from destination key
    assign w_idx = {i_cfg.mode_flags[1] && r_s1.src_match,
                    i_cfg.mode_flags[2] && r_s1.dst_match};

    always_comb begin
        n_s2.clip = i_cfg.mode_flags[0] && !(r_s1.x_ok && r_s1.y_ok);
        n_s2.code = brc_pkg::t_rop'(i_cfg.rop_table[{w_idx, 2'b00} +: 4]);
        n_s2.src  = r_s1.src;
        n_s2.dst  = r_s1.dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        r_s2 <= n_s2;
    end

    assign o_valid = r_s2_valid;
    assign o_mix   = r_s2;

    `BRC_ASSERT_NEXT(a_clip_needs_enable, r_s1_valid && !i_cfg.mode_flags[0], !o_mix.clip)
    `BRC_ASSERT_NEXT(a_valid_carried, r_s1_valid, o_valid)

endmodule

### rtl/brc_mix.sv
// stage three: boolean mix of source and destination, clipped pixels keep destination
// depends on brc_pkg and the assertion macro header
`include "blit_rop_chroma_clip_pixel_core_defines.svh"
module brc_mix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  brc_pkg::t_mix i_mix,
    output logic          o_done,
    output brc_pkg::t_res o_res
);

    function automatic logic [brc_pkg::PixBits-1:0] rop_mix(
        input logic [brc_pkg::PixBits-1:0] s,
        input logic [brc_pkg::PixBits-1:0] d,
        input brc_pkg::t_rop               code
    );
        logic [brc_pkg::PixBits-1:0] v;
        unique case (code)
            brc_pkg::ROP_ZERO:   v = '0;
            brc_pkg::ROP_NOR:    v = ~(s | d);
            brc_pkg::ROP_NS_AND: v = ~s & d;
            brc_pkg::ROP_NOT_S:  v = ~s;
            brc_pkg::ROP_S_ANDN: v = s & ~d;
            brc_pkg::ROP_NOT_D:  v = ~d;
            brc_pkg::ROP_XOR:    v = s ^ d;
            brc_pkg::ROP_NAND:   v = ~(s & d);
            brc_pkg::ROP_AND:    v = s & d;
            brc_pkg::ROP_XNOR:   v = ~(s ^ d);
            brc_pkg::ROP_DST:    v = d;
            brc_pkg::ROP_NS_OR:  v = ~s | d;
            brc_pkg::ROP_SRC:    v = s;
            brc_pkg::ROP_S_ORN:  v = s | ~d;
            brc_pkg::ROP_OR:     v = s | d;
            brc_pkg::ROP_ONES:   v = '1;
        endcase
        return v;
    endfunction

    logic          r_done;
    brc_pkg::t_res r_res;
    brc_pkg::t_res n_res;

    always_comb begin
        n_res.write_enable = !i_mix.clip;
        n_res.new_pixel    = i_mix.clip ? i_mix.dst : rop_mix(i_mix.src, i_mix.dst, i_mix.code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `BRC_ASSERT_NEXT(a_clip_keeps_dst, i_valid && i_mix.clip, !o_res.write_enable && o_res.new_pixel == $past(i_mix.dst))

endmodule

### rtl/blit_rop_chroma_clip_pixel_core.sv
// top level of the blit raster-op core: apb registers, compare stages, mix stage
// depends on brc_pkg, brc_regs, brc_test, brc_mix and the assertion macro header
//
// channel   direction  handshake                     payload
// request   in         i_start, o_busy               i_req   (brc_pkg::t_req)
// result    out        o_done strobe                 o_res   (brc_pkg::t_res)
// config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// one request per cycle; each result passes through the three register stages:
// compares, code select, mix and output
// o_busy is held low, the pipeline never stalls and results cannot be held off
// synchronous active-low reset clears the valid bits and loads register defaults
`include "blit_rop_chroma_clip_pixel_core_defines.svh"
module blit_rop_chroma_clip_pixel_core #(
    parameter int COORD_BITS = brc_pkg::CoordBitsDefault
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  brc_pkg::t_req                    i_req,
    output logic                             o_busy,
    output logic                             o_done,
    output brc_pkg::t_res                    o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [brc_pkg::ApbAddrBits-1:0]  paddr,
    input  logic [brc_pkg::ApbDataBits-1:0]  pwdata,
    output logic [brc_pkg::ApbDataBits-1:0]  prdata,
    output logic                             pready
);

    brc_pkg::t_cfg w_cfg;
    brc_pkg::t_mix w_mix;
    logic          w_mix_valid;
    logic          w_accept;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    brc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    brc_test #(
        .COORD_BITS (COORD_BITS)
    ) u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_req   (i_req),
        .i_cfg   (w_cfg),
        .o_valid (w_mix_valid),
        .o_mix   (w_mix)
    );

    brc_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mix_valid),
        .i_mix   (w_mix),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    `BRC_ASSERT_IMPL(a_done_follows_start, o_done, $past(i_start, 3))
    `BRC_ASSERT_IMPL(a_clipped_is_dst, o_done && !o_res.write_enable, o_res.new_pixel == $past(i_req.dst_pixel, 3))

endmodule

### tb/tb_top.sv
// self-checking testbench for blit_rop_chroma_clip_pixel_core: clip window, chroma keys, rop mix
// depends on brc_pkg and the core; predicts each pixel write and compares it with o_res in order
`timescale 1ns / 1ps
module tb_top;

    localparam int ModeClip    = 0;
    localparam int ModeSrcKey  = 1;
    localparam int ModeDstKey  = 2;
    localparam int CoordBits   = brc_pkg::CoordBitsDefault;
    localparam int RandPhases  = 11;
    localparam int PhaseItems  = 150;
    localparam int DrainCycles = 10;
    localparam int StallLimit  = 1000;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_start;
    brc_pkg::t_req                   i_req;
    logic                            o_busy;
    logic                            o_done;
    brc_pkg::t_res                   o_res;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [brc_pkg::ApbAddrBits-1:0] paddr;
    logic [brc_pkg::ApbDataBits-1:0] pwdata;
    logic [brc_pkg::ApbDataBits-1:0] prdata;
    logic                            pready;

    brc_pkg::t_cfg cfg;
    brc_pkg::t_res pending_writes[$];
    brc_pkg::t_res want_res;
    int            mismatch_count = 0;
    int            stall_cycles = 0;

    blit_rop_chroma_clip_pixel_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic key_match(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
        return p[15:11] >= lo[15:11] && p[15:11] <= hi[15:11] &&
               p[10:5]  >= lo[10:5]  && p[10:5]  <= hi[10:5]  &&
               p[4:0]   >= lo[4:0]   && p[4:0]   <= hi[4:0];
    endfunction

    function automatic brc_pkg::t_res predict_pixel(brc_pkg::t_req r);
        brc_pkg::t_res res;
        logic [11:0]   mask;
        logic [11:0]   x;
        logic [11:0]   y;
        logic [1:0]    sel;
        brc_pkg::t_rop code;
        logic [15:0]   s;
        logic [15:0]   d;
        logic [15:0]   v;
        mask = (12'd1 << CoordBits) - 12'd1;
        x = 12'(r.pixel_x) & mask;
        y = 12'(r.pixel_y) & mask;
        s = r.src_pixel;
        d = r.dst_pixel;
        if (cfg.mode_flags[ModeClip] &&
            (x < cfg.clip_x_range[11:0] || x >= cfg.clip_x_range[23:12] ||
             y < cfg.clip_y_range[11:0] || y >= cfg.clip_y_range[23:12])) begin
            res.write_enable = 1'b0;
            res.new_pixel = d;
            return res;
        end
        sel[1] = cfg.mode_flags[ModeSrcKey] && key_match(s, cfg.src_key_low, cfg.src_key_high);
        sel[0] = cfg.mode_flags[ModeDstKey] && key_match(d, cfg.dst_key_low, cfg.dst_key_high);
        code = brc_pkg::t_rop'(cfg.rop_table[{sel, 2'b00} +: 4]);
        case (code)
            brc_pkg::ROP_ZERO:   v = '0;
            brc_pkg::ROP_NOR:    v = ~(s | d);
            brc_pkg::ROP_NS_AND: v = ~s & d;
            brc_pkg::ROP_NOT_S:  v = ~s;
            brc_pkg::ROP_S_ANDN: v = s & ~d;
            brc_pkg::ROP_NOT_D:  v = ~d;
            brc_pkg::ROP_XOR:    v = s ^ d;
            brc_pkg::ROP_NAND:   v = ~(s & d);
            brc_pkg::ROP_AND:    v = s & d;
            brc_pkg::ROP_XNOR:   v = ~(s ^ d);
            brc_pkg::ROP_DST:    v = d;
            brc_pkg::ROP_NS_OR:  v = ~s | d;
            brc_pkg::ROP_SRC:    v = s;
            brc_pkg::ROP_S_ORN:  v = s | ~d;
            brc_pkg::ROP_OR:     v = s | d;
            default:             v = '1;
        endcase
        res.write_enable = 1'b1;
        res.new_pixel = v;
        return res;
    endfunction

    function automatic logic [10:0] rand_coord(logic [11:0] lo_edge, logic [11:0] hi_edge);
        logic [11:0] c;
        case ($urandom_range(5, 0))
            0:       c = lo_edge - 12'd1;
            1:       c = lo_edge;
            2:       c = hi_edge - 12'd1;
            3:       c = hi_edge;
            default: c = 12'($urandom());
        endcase
        return c[10:0];
    endfunction

    function automatic logic [15:0] rand_pixel(logic [15:0] lo, logic [15:0] hi);
        logic [15:0] p;
        p = 16'($urandom());
        if ($urandom_range(2, 0) == 0) begin
            if (lo[15:11] <= hi[15:11])
                p[15:11] = 5'($urandom_range(int'(hi[15:11]), int'(lo[15:11])));
            if (lo[10:5] <= hi[10:5])
                p[10:5] = 6'($urandom_range(int'(hi[10:5]), int'(lo[10:5])));
            if (lo[4:0] <= hi[4:0])
                p[4:0] = 5'($urandom_range(int'(hi[4:0]), int'(lo[4:0])));
        end
        return p;
    endfunction

    // {high, low}; mostly ordered per channel
    function automatic logic [31:0] rand_key_pair();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] lo;
        logic [15:0] hi;
        a = 16'($urandom());
        b = 16'($urandom());
        if ($urandom_range(7, 0) == 0)
            return {b, a};
        lo[15:11] = (a[15:11] < b[15:11]) ? a[15:11] : b[15:11];
        hi[15:11] = (a[15:11] < b[15:11]) ? b[15:11] : a[15:11];
        lo[10:5]  = (a[10:5] < b[10:5]) ? a[10:5] : b[10:5];
        hi[10:5]  = (a[10:5] < b[10:5]) ? b[10:5] : a[10:5];
        lo[4:0]   = (a[4:0] < b[4:0]) ? a[4:0] : b[4:0];
        hi[4:0]   = (a[4:0] < b[4:0]) ? b[4:0] : a[4:0];
        return {hi, lo};
    endfunction

    function automatic logic [31:0] rand_clip_range();
        logic [11:0] lo_edge;
        logic [11:0] hi_edge;
        if ($urandom_range(7, 0) == 0)
            return 32'($urandom() & 32'h00FF_FFFF);
        lo_edge = 12'($urandom_range(2100, 0));
        hi_edge = lo_edge + 12'($urandom_range(700, 0));
        return {8'h00, hi_edge, lo_edge};
    endfunction

    task automatic write_reg(brc_pkg::t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            brc_pkg::REG_MODE_FLAGS:
                cfg.mode_flags   = value[brc_pkg::ModeBits-1:0];
            brc_pkg::REG_CLIP_X_RANGE:
                cfg.clip_x_range = value[brc_pkg::RangeBits-1:0];
            brc_pkg::REG_CLIP_Y_RANGE:
                cfg.clip_y_range = value[brc_pkg::RangeBits-1:0];
            brc_pkg::REG_SRC_KEY_LOW:
                cfg.src_key_low  = value[brc_pkg::PixBits-1:0];
            brc_pkg::REG_SRC_KEY_HIGH:
                cfg.src_key_high = value[brc_pkg::PixBits-1:0];
            brc_pkg::REG_DST_KEY_LOW:
                cfg.dst_key_low  = value[brc_pkg::PixBits-1:0];
            brc_pkg::REG_DST_KEY_HIGH:
                cfg.dst_key_high = value[brc_pkg::PixBits-1:0];
            default:
                cfg.rop_table    = value[brc_pkg::PixBits-1:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_pixel(brc_pkg::t_req r, int gap, logic hold);
        i_start <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        pending_writes.push_back(predict_pixel(r));
        if (gap > 0 || hold) begin
            i_start <= 1'b0;
            while (hold && pending_writes.size() != 0) @(posedge i_clk);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic quiesce();
        i_start <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_default_copy();
        brc_pkg::t_req item;
        item = '{src_pixel: 16'h0000, dst_pixel: 16'hFFFF, pixel_x: 11'd0, pixel_y: 11'd0};
        send_pixel(item, 0, 1'b0);
        item = '{src_pixel: 16'hFFFF, dst_pixel: 16'h0000, pixel_x: 11'h7FF, pixel_y: 11'h7FF};
        send_pixel(item, 0, 1'b0);
    endtask

    // bit 15 of each pixel steers the chroma match so every table entry gets used
    task automatic test_rop_codes();
        brc_pkg::t_req item;
        logic [1:0]    sel;
        quiesce();
        write_reg(brc_pkg::REG_MODE_FLAGS, 32'((1 << ModeSrcKey) | (1 << ModeDstKey)));
        write_reg(brc_pkg::REG_SRC_KEY_LOW, 32'h0000);
        write_reg(brc_pkg::REG_SRC_KEY_HIGH, 32'h7FFF);
        write_reg(brc_pkg::REG_DST_KEY_LOW, 32'h0000);
        write_reg(brc_pkg::REG_DST_KEY_HIGH, 32'h7FFF);
        for (int t = 0; t < 4; t++) begin
            quiesce();
            write_reg(brc_pkg::REG_ROP_TABLE, 32'h3210 + 32'(t) * 32'h4444);
            for (int k = 0; k < 4; k++) begin
                sel = 2'(k);
                item.src_pixel = {~sel[1], 15'($urandom())};
                item.dst_pixel = {~sel[0], 15'($urandom())};
                item.pixel_x   = 11'($urandom());
                item.pixel_y   = 11'($urandom());
                send_pixel(item, 0, 1'b0);
            end
        end
    endtask

    task automatic test_clip_edges();
        brc_pkg::t_req item;
        quiesce();
        write_reg(brc_pkg::REG_MODE_FLAGS, 32'(1 << ModeClip));
        write_reg(brc_pkg::REG_CLIP_X_RANGE, {8'h00, 12'd20, 12'd10});
        write_reg(brc_pkg::REG_CLIP_Y_RANGE, {8'h00, 12'd6, 12'd5});
        item = '{src_pixel: 16'h1234, dst_pixel: 16'hBEEF, pixel_x: 11'd10, pixel_y: 11'd5};
        send_pixel(item, 0, 1'b0);
        item.pixel_x = 11'd9;
        send_pixel(item, 0, 1'b0);
        item.pixel_x = 11'd19;
        send_pixel(item, 0, 1'b0);
        item.pixel_x = 11'd20;
        send_pixel(item, 0, 1'b0);
        item.pixel_x = 11'd10;
        item.pixel_y = 11'd6;
        send_pixel(item, 0, 1'b0);
        item.pixel_y = 11'd4;
        send_pixel(item, 0, 1'b0);
        // empty window
        quiesce();
        write_reg(brc_pkg::REG_CLIP_X_RANGE, {8'h00, 12'd100, 12'd100});
        item.pixel_x = 11'd100;
        item.pixel_y = 11'd5;
        send_pixel(item, 0, 1'b0);
        // widest window
        quiesce();
        write_reg(brc_pkg::REG_CLIP_X_RANGE, {8'h00, 12'hFFF, 12'h000});
        write_reg(brc_pkg::REG_CLIP_Y_RANGE, {8'h00, 12'hFFF, 12'h000});
        item.pixel_x = 11'h7FF;
        item.pixel_y = 11'h7FF;
        send_pixel(item, 0, 1'b0);
    endtask

    // source key has red min above max, destination key checked at its exact bounds
    task automatic test_chroma_limits();
        brc_pkg::t_req item;
        quiesce();
        write_reg(brc_pkg::REG_MODE_FLAGS, 32'((1 << ModeSrcKey) | (1 << ModeDstKey)));
        write_reg(brc_pkg::REG_SRC_KEY_LOW, 32'hF800);
        write_reg(brc_pkg::REG_SRC_KEY_HIGH, 32'h07FF);
        write_reg(brc_pkg::REG_DST_KEY_LOW, 32'h0841);
        write_reg(brc_pkg::REG_DST_KEY_HIGH, 32'hF7BE);
        write_reg(brc_pkg::REG_ROP_TABLE, 32'hE6A5);
        item = '{src_pixel: 16'h0000, dst_pixel: 16'h0841, pixel_x: 11'd3, pixel_y: 11'd7};
        send_pixel(item, 0, 1'b0);
        item.src_pixel = 16'hFFFF;
        item.dst_pixel = 16'hF7BE;
        send_pixel(item, 0, 1'b0);
        item.src_pixel = 16'h07FF;
        item.dst_pixel = 16'h0840;
        send_pixel(item, 0, 1'b0);
        item.src_pixel = 16'hF800;
        item.dst_pixel = 16'hF7BF;
        send_pixel(item, 0, 1'b0);
    endtask

    task automatic load_config(int kind);
        logic [31:0] pair;
        if (kind < 2) begin
            for (int r = 0; r < 8; r++)
                write_reg(brc_pkg::t_reg_idx'(r),
                          (kind == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF);
        end else begin
            write_reg(brc_pkg::REG_MODE_FLAGS, 32'($urandom_range(7, 0)));
            write_reg(brc_pkg::REG_CLIP_X_RANGE, rand_clip_range());
            write_reg(brc_pkg::REG_CLIP_Y_RANGE, rand_clip_range());
            pair = rand_key_pair();
            write_reg(brc_pkg::REG_SRC_KEY_LOW, {16'h0000, pair[15:0]});
            write_reg(brc_pkg::REG_SRC_KEY_HIGH, {16'h0000, pair[31:16]});
            pair = rand_key_pair();
            write_reg(brc_pkg::REG_DST_KEY_LOW, {16'h0000, pair[15:0]});
            write_reg(brc_pkg::REG_DST_KEY_HIGH, {16'h0000, pair[31:16]});
            write_reg(brc_pkg::REG_ROP_TABLE, 32'($urandom() & 32'hFFFF));
        end
    endtask

    task automatic test_random_traffic();
        brc_pkg::t_req item;
        int            idle_pct;
        int            gap;
        logic          hold;
        for (int phase = 0; phase < RandPhases; phase++) begin
            quiesce();
            load_config(phase);
            idle_pct = (phase == RandPhases - 1) ? 0 : $urandom_range(40, 0);
            for (int n = 0; n < PhaseItems; n++) begin
                item.src_pixel = rand_pixel(cfg.src_key_low, cfg.src_key_high);
                item.dst_pixel = rand_pixel(cfg.dst_key_low, cfg.dst_key_high);
                item.pixel_x   = rand_coord(cfg.clip_x_range[11:0], cfg.clip_x_range[23:12]);
                item.pixel_y   = rand_coord(cfg.clip_y_range[11:0], cfg.clip_y_range[23:12]);
                gap  = ($urandom_range(99, 0) < idle_pct) ? $urandom_range(11, 1) : 0;
                hold = (phase != RandPhases - 1) &&
                       ((phase == 3 && n == 75) || $urandom_range(199, 0) == 0);
                send_pixel(item, gap, hold);
            end
        end
        quiesce();
    endtask

    always @(posedge i_clk) begin
        if (o_done) begin
            if (pending_writes.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, o_res);
                mismatch_count++;
            end else begin
                want_res = pending_writes.pop_front();
                if (o_res.write_enable !== want_res.write_enable) begin
                    $display("%0t write_enable: expected %b, actual %b",
                             $time, want_res.write_enable, o_res.write_enable);
                    mismatch_count++;
                end
                if (o_res.new_pixel !== want_res.new_pixel) begin
                    $display("%0t new_pixel: expected %h, actual %h",
                             $time, want_res.new_pixel, o_res.new_pixel);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || (psel && penable && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cfg = '0;
        cfg.rop_table = brc_pkg::RopTableReset;
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_req   <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_copy();
        test_rop_codes();
        test_clip_edges();
        test_chroma_limits();
        test_random_traffic();
        quiesce();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0 && pending_writes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/brc_pkg.sv
rtl/brc_regs.sv
rtl/brc_test.sv
rtl/brc_mix.sv
rtl/blit_rop_chroma_clip_pixel_core.sv
tb/tb_top.sv
